FILE: hw/rtl/nrm_pkg.sv
// nrm_pkg: field widths, input kind codes and shared types of the delta-R matcher
// no dependencies; used by every other file of the block except nrm_ram
`default_nettype none

package nrm_pkg;

    // field widths
    localparam int KIND_W  = 2;
    localparam int ETA_W   = 16;
    localparam int PHI_W   = 15;
    localparam int MAXD_W  = 17;
    localparam int INDEX_W = 7;

    // distance arithmetic widths
    localparam int DE_W    = ETA_W + 1;
    localparam int DP_W    = PHI_W + 1;
    localparam int AE_W    = ETA_W;
    localparam int AP_W    = PHI_W;
    localparam int D2_W    = 2 * AE_W + 1;
    localparam int BEST_W  = 2 * MAXD_W;

    // largest phi difference magnitude before wrapping
    localparam int PHI_SPAN = 32767;

    // square root unit
    localparam int ROOT_W     = MAXD_W;
    localparam int ROOT_STEPS = BEST_W / 2;
    localparam int ROOT_CNT_W = 5;
    localparam int REM_W      = ROOT_W + 4;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // register reset and no-match code
    localparam logic [MAXD_W-1:0]         MAX_DIST_RESET = 17'd1638;
    localparam logic signed [INDEX_W-1:0] NO_MATCH       = -7'sd1;

    // tag that travels with each stored object through the distance pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nrm_in_if.sv
// nrm_in_if: input channel of the delta-R matcher (kind, eta, phi words)
// depends on nrm_pkg for the field widths
`default_nettype none

interface nrm_in_if;
    logic                              valid;
    logic                              ready;
    logic [nrm_pkg::KIND_W-1:0]        kind;
    logic signed [nrm_pkg::ETA_W-1:0]  eta;
    logic signed [nrm_pkg::PHI_W-1:0]  phi;

    modport source (output valid, kind, eta, phi, input ready);
    modport sink   (input valid, kind, eta, phi, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nrm_out_if.sv
// nrm_out_if: result channel of the delta-R matcher (match_index, distance words)
// depends on nrm_pkg for the field widths
`default_nettype none

interface nrm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [nrm_pkg::INDEX_W-1:0]  match_index;
    logic [nrm_pkg::MAXD_W-1:0]          distance;

    modport source (output valid, match_index, distance, input ready);
    modport sink   (input valid, match_index, distance, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nearest_delta_r_match.sv
// nearest_delta_r_match: top level, sequencer, reference RAM and result register
// depends on nrm_pkg, nrm_in_if, nrm_out_if, nrm_ram, nrm_dist_unit, nrm_isqrt
//
//   channel   dir  handshake         payload
//   in_ch     in   valid / ready     kind, eta, phi
//   out_ch    out  valid / ready     match_index, distance
//   cfg       in   cfg_wr_en         cfg_wr_data (max_distance)
//
// clear and store words are taken while idle and may follow back to back.
// a query holds in_ch.ready low while it walks the RAM over the N stored objects,
// drains the read and distance pipeline, decides, runs the root steps on a match and
// loads the result; an empty list goes straight to the result. a finished query waits
// while the result register is full; the next word may enter while a result waits.
// rst_n clears the list count and the sequencer and presets the threshold.
`default_nettype none

module nearest_delta_r_match #(
    parameter int MAX_REFS = 64,
    parameter int PI_FIXED = 12868
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    nrm_in_if.sink                          in_ch,
    nrm_out_if.source                       out_ch,
    input  wire logic                       cfg_wr_en,
    input  wire logic [nrm_pkg::MAXD_W-1:0] cfg_wr_data
);

    localparam int CNT_W   = $clog2(MAX_REFS + 1);
    localparam int ADDR_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int ENTRY_W = nrm_pkg::ETA_W + nrm_pkg::PHI_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               scan_idx_reg;
    logic                           found_reg;
    logic                           out_valid_reg;
    logic [nrm_pkg::MAXD_W-1:0]     max_distance_reg;
    nrm_pkg::tag_t                  rd_tag_reg;
    logic [ADDR_W-1:0]              rd_idx_reg;

    logic signed [nrm_pkg::ETA_W-1:0]   q_eta_reg;
    logic signed [nrm_pkg::PHI_W-1:0]   q_phi_reg;
    logic [nrm_pkg::BEST_W-1:0]         thr_sq_reg;
    logic [nrm_pkg::BEST_W-1:0]         best_reg;
    logic [ADDR_W-1:0]                  best_idx_reg;
    logic signed [nrm_pkg::INDEX_W-1:0] out_idx_reg;
    logic [nrm_pkg::MAXD_W-1:0]         out_dist_reg;

    logic                           in_take;
    logic                           out_free;
    logic                           is_full;
    logic                           store_wr;
    logic                           query_take;
    logic                           issue;
    logic                           scan_last;
    logic                           better;
    logic                           root_start;
    logic                           root_done;
    logic [nrm_pkg::ROOT_W-1:0]     root_val;
    logic [nrm_pkg::BEST_W-1:0]     cur_best;
    logic [ENTRY_W-1:0]             rd_data;
    nrm_pkg::tag_t                  dist_tag;
    logic [ADDR_W-1:0]              dist_idx;
    logic [nrm_pkg::D2_W-1:0]       dist_d2;

    // handshake and word decode
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign is_full     = (count_reg == CNT_W'(MAX_REFS));
    assign store_wr    = in_take && (in_ch.kind == nrm_pkg::KIND_STORE) && !is_full;
    assign query_take  = in_take && (in_ch.kind == nrm_pkg::KIND_QUERY);
    assign issue       = (state_reg == S_SCAN);
    assign scan_last   = ((scan_idx_reg + CNT_W'(1)) == count_reg);

    // running best against threshold; strict compare keeps the first-loaded winner
    assign cur_best = found_reg ? best_reg : thr_sq_reg;
    assign better   = dist_tag.valid && ({1'b0, dist_d2} < cur_best);

    // reference object store
    nrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REFS)
    ) u_ref_ram (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({in_ch.eta, in_ch.phi}),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // squared distance pipeline
    nrm_dist_unit #(
        .PI_FIXED (PI_FIXED),
        .IDX_W    (ADDR_W)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag_reg),
        .idx_in  (rd_idx_reg),
        .q_eta   (q_eta_reg),
        .q_phi   (q_phi_reg),
        .r_eta   ($signed(rd_data[ENTRY_W-1 -: nrm_pkg::ETA_W])),
        .r_phi   ($signed(rd_data[nrm_pkg::PHI_W-1:0])),
        .tag_out (dist_tag),
        .idx_out (dist_idx),
        .d2      (dist_d2)
    );

    // square root of the winning distance
    nrm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (best_reg),
        .done     (root_done),
        .root     (root_val)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        root_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (query_take)
                begin
                    state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (dist_tag.valid && dist_tag.last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (found_reg)
                begin
                    root_start = 1'b1;
                    state_next = S_ROOT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            scan_idx_reg     <= '0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            max_distance_reg <= nrm_pkg::MAX_DIST_RESET;
            rd_tag_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                max_distance_reg <= cfg_wr_data;
            end

            // list fill count
            if (in_take && (in_ch.kind == nrm_pkg::KIND_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (store_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            // scan index and found flag
            if (query_take)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end

            rd_tag_reg.valid <= issue;
            rd_tag_reg.last  <= issue && scan_last;

            // result register
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query_take)
        begin
            q_eta_reg <= in_ch.eta;
            q_phi_reg <= in_ch.phi;
        end

        thr_sq_reg <= nrm_pkg::BEST_W'(max_distance_reg)
                      * nrm_pkg::BEST_W'(max_distance_reg);
        rd_idx_reg <= scan_idx_reg[ADDR_W-1:0];

        if (better)
        begin
            best_reg     <= {1'b0, dist_d2};
            best_idx_reg <= dist_idx;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_idx_reg  <= found_reg ? $signed(nrm_pkg::INDEX_W'(best_idx_reg))
                                      : nrm_pkg::NO_MATCH;
            out_dist_reg <= found_reg ? root_val : max_distance_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.match_index = out_idx_reg;
    assign out_ch.distance    = out_dist_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nrm_ram.sv
// nrm_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module nrm_ram #(
    parameter int WIDTH  = 31,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nrm_dist_unit.sv
// nrm_dist_unit: four-stage squared delta-R unit, one stored object per cycle
// depends on nrm_pkg for widths and the tag type
`default_nettype none

module nrm_dist_unit #(
    parameter int PI_FIXED = 12868,
    parameter int IDX_W    = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire nrm_pkg::tag_t                     tag_in,
    input  wire logic [IDX_W-1:0]                  idx_in,
    input  wire logic signed [nrm_pkg::ETA_W-1:0]  q_eta,
    input  wire logic signed [nrm_pkg::PHI_W-1:0]  q_phi,
    input  wire logic signed [nrm_pkg::ETA_W-1:0]  r_eta,
    input  wire logic signed [nrm_pkg::PHI_W-1:0]  r_phi,
    output nrm_pkg::tag_t                          tag_out,
    output logic [IDX_W-1:0]                       idx_out,
    output logic [nrm_pkg::D2_W-1:0]               d2
);

    // wrap working width and number of conditional wrap steps
    localparam int WRAP_W     = $clog2(nrm_pkg::PHI_SPAN + 1 + 2 * PI_FIXED) + 2;
    localparam int WRAP_STEPS = (nrm_pkg::PHI_SPAN + 2 * PI_FIXED - 1) / (2 * PI_FIXED) + 1;
    localparam logic signed [WRAP_W-1:0] PI_S     = WRAP_W'(PI_FIXED);
    localparam logic signed [WRAP_W-1:0] NEG_PI_S = -WRAP_W'(PI_FIXED);
    localparam logic signed [WRAP_W-1:0] TWO_PI_S = WRAP_W'(2 * PI_FIXED);

    nrm_pkg::tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    logic signed [nrm_pkg::DE_W-1:0] de_reg;
    logic signed [nrm_pkg::DP_W-1:0] dp_reg;
    logic [nrm_pkg::AE_W-1:0]        ae_reg;
    logic [nrm_pkg::AP_W-1:0]        ap_reg;
    logic [2*nrm_pkg::AE_W-1:0]      sq_e_reg;
    logic [2*nrm_pkg::AP_W-1:0]      sq_p_reg;
    logic [nrm_pkg::D2_W-1:0]        d2_reg;

    logic signed [nrm_pkg::DE_W-1:0] de_next;
    logic signed [nrm_pkg::DP_W-1:0] dp_next;
    logic signed [WRAP_W-1:0]        wrap_val;
    logic signed [WRAP_W-1:0]        abs_p;
    logic signed [nrm_pkg::DE_W-1:0] abs_e;

    // stage 1: coordinate differences
    assign de_next = {q_eta[nrm_pkg::ETA_W-1], q_eta} - {r_eta[nrm_pkg::ETA_W-1], r_eta};
    assign dp_next = {q_phi[nrm_pkg::PHI_W-1], q_phi} - {r_phi[nrm_pkg::PHI_W-1], r_phi};

    // stage 2: wrap phi difference into (-pi, pi], then magnitudes
    always_comb
    begin
        wrap_val = {{(WRAP_W - nrm_pkg::DP_W){dp_reg[nrm_pkg::DP_W-1]}}, dp_reg};
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (wrap_val > PI_S)
            begin
                wrap_val = wrap_val - TWO_PI_S;
            end
            else if (wrap_val <= NEG_PI_S)
            begin
                wrap_val = wrap_val + TWO_PI_S;
            end
        end
        abs_p = (wrap_val < 0) ? -wrap_val : wrap_val;
        abs_e = (de_reg < 0) ? -de_reg : de_reg;
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    // data pipeline: differences, magnitudes, squares, sum
    always_ff @(posedge clk)
    begin
        idx1_reg <= idx_in;
        de_reg   <= de_next;
        dp_reg   <= dp_next;

        idx2_reg <= idx1_reg;
        ae_reg   <= abs_e[nrm_pkg::AE_W-1:0];
        ap_reg   <= abs_p[nrm_pkg::AP_W-1:0];

        idx3_reg <= idx2_reg;
        sq_e_reg <= (2 * nrm_pkg::AE_W)'(ae_reg) * (2 * nrm_pkg::AE_W)'(ae_reg);
        sq_p_reg <= (2 * nrm_pkg::AP_W)'(ap_reg) * (2 * nrm_pkg::AP_W)'(ap_reg);

        idx4_reg <= idx3_reg;
        d2_reg   <= {1'b0, sq_e_reg}
                    + {{(nrm_pkg::D2_W - 2 * nrm_pkg::AP_W){1'b0}}, sq_p_reg};
    end

    assign tag_out = tag4_reg;
    assign idx_out = idx4_reg;
    assign d2      = d2_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nrm_isqrt.sv
// nrm_isqrt: bit-serial floor integer square root, one result bit per cycle
// depends on nrm_pkg for widths and step count
`default_nettype none

module nrm_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [nrm_pkg::BEST_W-1:0]    radicand,
    output logic                               done,
    output logic [nrm_pkg::ROOT_W-1:0]         root
);

    logic [nrm_pkg::BEST_W-1:0]     x_reg;
    logic [nrm_pkg::REM_W-1:0]      rem_reg;
    logic [nrm_pkg::ROOT_W-1:0]     root_reg;
    logic [nrm_pkg::ROOT_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [nrm_pkg::REM_W-1:0] rem_sh;
    logic [nrm_pkg::REM_W-1:0] trial;
    logic [nrm_pkg::REM_W-1:0] rem_next;
    logic                      take;

    // one digit step: bring down two bits, try subtracting 4*root+1
    assign rem_sh   = {rem_reg[nrm_pkg::REM_W-3:0], x_reg[nrm_pkg::BEST_W-1 -: 2]};
    assign trial    = {{(nrm_pkg::REM_W - nrm_pkg::ROOT_W - 2){1'b0}}, root_reg, 2'b01};
    assign take     = (rem_sh >= trial);
    assign rem_next = take ? (rem_sh - trial) : rem_sh;

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= nrm_pkg::ROOT_CNT_W'(nrm_pkg::ROOT_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - nrm_pkg::ROOT_CNT_W'(1);
            if (cnt_reg == nrm_pkg::ROOT_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[nrm_pkg::BEST_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[nrm_pkg::ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
